[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[hw/rtl/pngacf_pkg.sv]
// ---------------------------------------------------------------------------
// PNG ancillary chunk filter package
// Types, constants and the signature table shared by the filter modules.
// ---------------------------------------------------------------------------
package pngacf_pkg;

    localparam int LENGTH_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        PH_SIG  = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_SKIP = 3'd3,
        PH_DONE = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_SIG = 2'd1,
        ST_ANC     = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } item_t;

    localparam logic [2:0] SIG_LAST    = 3'd7;
    localparam logic [2:0] LEN_LAST    = 3'd3;
    localparam logic [7:0] ANC_LOW     = 8'd97;
    localparam logic [7:0] ANC_HIGH    = 8'd127;
    localparam logic [7:0] TYPE_END    = 8'd0;
    localparam int         SKIP_EXTRA  = 7;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0: b = 8'h89;
            3'd1: b = 8'h50;
            3'd2: b = 8'h4E;
            3'd3: b = 8'h47;
            3'd4: b = 8'h0D;
            3'd5: b = 8'h0A;
            3'd6: b = 8'h1A;
            3'd7: b = 8'h0A;
        endcase
        return b;
    endfunction

endpackage

[hw/rtl/pngacf_in_stage.sv]
// ---------------------------------------------------------------------------
// Input register
// Captures one byte beat and holds it until the core consumes it.
// ---------------------------------------------------------------------------
module pngacf_in_stage
    import pngacf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       s_axis_tlast,
    input  logic       advance,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_axis_tready = !valid_reg || advance;
    assign valid_next    = s_axis_tready ? s_axis_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg.data_byte   <= s_axis_tdata;
            item_reg.end_of_file <= s_axis_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[hw/rtl/pngacf_core.sv]
// ---------------------------------------------------------------------------
// Chunk walker and result register
// Tracks signature and chunk state per byte and registers the verdict.
// ---------------------------------------------------------------------------
module pngacf_core
    import pngacf_pkg::*;
#(
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  item_t      item,
    output logic       advance,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata
);

    localparam int SKIP_WIDTH = LENGTH_WIDTH + 1;

    phase_t                  phase_reg, phase_next;
    logic [2:0]              idx_reg, idx_next;
    logic [LENGTH_WIDTH-1:0] len_reg, len_next;
    logic [SKIP_WIDTH-1:0]   skip_reg, skip_next, skip_dec;
    logic                    out_valid_reg, out_valid_next;
    status_t                 status_reg, status_c;
    logic [2:0]              sig_idx_reg, sig_idx_c;
    logic                    emit;
    logic [7:0]              b;
    logic                    eof;
    logic                    is_anc;

    assign b       = item.data_byte;
    assign eof     = item.end_of_file;
    assign is_anc  = (b >= ANC_LOW) && (b <= ANC_HIGH);
    assign advance = item_valid && (!out_valid_reg || m_axis_tready);
    assign skip_dec = (skip_reg != '0) ? skip_reg - SKIP_WIDTH'(1) : skip_reg;

    always_comb
    begin
        emit      = 1'b0;
        status_c  = ST_OK;
        sig_idx_c = 3'd0;
        unique case (phase_reg)
            PH_SIG:
            begin
                if (b != sig_byte(idx_reg))
                begin
                    emit      = 1'b1;
                    status_c  = ST_BAD_SIG;
                    sig_idx_c = idx_reg;
                end
                else if (idx_reg != SIG_LAST && eof)
                begin
                    emit      = 1'b1;
                    status_c  = ST_BAD_SIG;
                    sig_idx_c = idx_reg + 3'd1;
                end
            end
            PH_TYPE:
            begin
                if (b == TYPE_END)
                begin
                    emit = 1'b1;
                end
                else if (is_anc)
                begin
                    emit     = 1'b1;
                    status_c = ST_ANC;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        if (eof && !emit && phase_reg != PH_DONE)
        begin
            emit      = 1'b1;
            status_c  = ST_OK;
            sig_idx_c = 3'd0;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        skip_next  = skip_reg;
        unique case (phase_reg)
            PH_SIG:
            begin
                if (b == sig_byte(idx_reg))
                begin
                    if (idx_reg == SIG_LAST)
                    begin
                        phase_next = PH_LEN;
                        idx_next   = 3'd0;
                        len_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            PH_LEN:
            begin
                len_next = {len_reg[LENGTH_WIDTH-9:0], b};
                if (idx_reg == LEN_LAST)
                begin
                    idx_next   = 3'd0;
                    phase_next = PH_TYPE;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            PH_TYPE:
            begin
                skip_next  = {1'b0, len_reg} + SKIP_WIDTH'(SKIP_EXTRA);
                phase_next = PH_SKIP;
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    phase_next = PH_LEN;
                    idx_next   = 3'd0;
                    len_next   = '0;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
        if (emit)
        begin
            phase_next = PH_DONE;
        end
        if (eof)
        begin
            phase_next = PH_SIG;
            idx_next   = 3'd0;
            len_next   = '0;
            skip_next  = '0;
        end
    end

    assign out_valid_next = advance ? emit : (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SIG;
            idx_reg       <= 3'd0;
            len_reg       <= '0;
            skip_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                phase_reg <= phase_next;
                idx_reg   <= idx_next;
                len_reg   <= len_next;
                skip_reg  <= skip_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            status_reg  <= status_c;
            sig_idx_reg <= sig_idx_c;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, sig_idx_reg, status_reg};

endmodule

[hw/rtl/png_ancillary_chunk_filter.sv]
// ---------------------------------------------------------------------------
// PNG ancillary chunk filter
// Checks the PNG signature, walks the chunks and gives one verdict per file.
// ---------------------------------------------------------------------------
// Channel   Direction  Beat
// s_axis    in         one file byte, tlast on the final byte of the file
// m_axis    out        one verdict per file
//
// A new byte is accepted in every cycle while no verdict is stalled.
// A byte passes the input register, then the chunk walker and result register.
// A verdict is registered when the walker consumes its deciding byte from the input register.
// A stalled verdict stops the input register only when it also holds a byte.
// Reset returns the walker to the signature phase with no verdict pending.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module png_ancillary_chunk_filter
    import pngacf_pkg::*;
#(
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // data_byte[7:0]
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // status[1:0], signature_index[4:2], zero[7:5]
);

    logic  advance;
    logic  item_valid;
    item_t item;

    pngacf_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .advance       (advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    pngacf_core #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item          (item),
        .advance       (advance),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    `ASSERT_CHECK(a_verdict_from_byte,
        $rose(m_axis_tvalid) |-> $past(item_valid),
        "verdict without a byte")
    `ASSERT_CHECK(a_index_only_bad_sig,
        (m_axis_tvalid && m_axis_tdata[1:0] != ST_BAD_SIG) |-> (m_axis_tdata[4:2] == 3'd0),
        "signature index set without bad signature")
    `ASSERT_NEVER(a_stall_needs_full_reg,
        !s_axis_tready && !item_valid,
        "input stalled with empty register")

endmodule
